### sv/tcma_pkg.sv
package tcma_pkg;

  localparam int DEPTH_DEFAULT = 16;
  localparam int SAMPLE_W      = 12;
  localparam int PERIOD_W      = 8;
  localparam int TICK_W        = 8;

  localparam logic [PERIOD_W-1:0] PERIOD_RESET = PERIOD_W'(2);
  localparam logic [TICK_W-1:0]   TICK_MAX     = {TICK_W{1'b1}};

  localparam int IN_DATA_W  = 16;
  localparam int OUT_DATA_W = 32;

  // input tdata bit positions
  localparam int IN_RUN_BIT     = 0;
  localparam int IN_SAMPLE_LSB  = 1;
  localparam int IN_OK_BIT      = IN_SAMPLE_LSB + SAMPLE_W;
  localparam int IN_USED_W      = IN_OK_BIT + 1;

  // output tdata bit positions
  localparam int OUT_AVG_LSB    = 0;
  localparam int OUT_VALID_BIT  = OUT_AVG_LSB + SAMPLE_W;
  localparam int OUT_LAST_LSB   = OUT_VALID_BIT + 1;
  localparam int OUT_TAKEN_BIT  = OUT_LAST_LSB + SAMPLE_W;
  localparam int OUT_USED_W     = OUT_TAKEN_BIT + 1;

endpackage

### sv/tcma_ram.sv
module tcma_ram #(
  parameter int WIDTH = 12,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

### sv/torque_count_moving_average_unit.sv
// path: a result passes the p stage register and then the output register before it leaves on m_tdata
// throughput: one tick item per cycle while the stage is not held by a stalled output; the ring entry
//   to drop is prefetched from the window ram ahead of its transfer, so the read-modify-write never stalls
// one stage plus the output register let one more item in while a result waits
// reset (rst, synchronous): sum, fill count, ring pointer, tick counter cleared,
//   sample_period back to 2; the ram needs no clearing, the fill count masks it
module torque_count_moving_average_unit
  import tcma_pkg::*;
#(
  parameter int DEPTH = DEPTH_DEFAULT
) (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  cfg_we,
  input  logic [PERIOD_W-1:0]   cfg_wdata,
  input  logic                  s_tvalid,
  output logic                  s_tready,
  // motor_running, sample_value, sample_ok, zero pad
  input  logic [IN_DATA_W-1:0]  s_tdata,
  output logic                  m_tvalid,
  input  logic                  m_tready,
  // average, average_valid, latest_count, sample_taken, zero pad
  output logic [OUT_DATA_W-1:0] m_tdata
);

  localparam int ADDR_W  = $clog2(DEPTH);
  localparam int FILL_W  = $clog2(DEPTH + 1);
  localparam int SUM_W   = $clog2(DEPTH * ((1 << SAMPLE_W) - 1) + 1);
  // exact divide by DEPTH via reciprocal, valid for any sum below 2^SUM_W
  localparam int DIV_K   = SUM_W + $clog2(DEPTH);
  localparam int DIV_M_W = SUM_W + 1;
  localparam logic [DIV_M_W-1:0] DIV_M =
    DIV_M_W'(((1 << DIV_K) + DEPTH - 1) / DEPTH);
  localparam logic [FILL_W-1:0] FILL_FULL = FILL_W'(DEPTH);
  localparam logic [ADDR_W-1:0] POS_LAST  = ADDR_W'(DEPTH - 1);

  logic [PERIOD_W-1:0] sample_period;

  logic [ADDR_W-1:0]   write_pos, write_pos_next;
  logic [FILL_W-1:0]   fill_count, fill_count_next;
  logic [SUM_W-1:0]    window_sum, window_sum_next;
  logic [TICK_W-1:0]   tick_count, tick_count_next;
  logic [SAMPLE_W-1:0] last_count, last_count_next;

  logic                p_v;
  logic [SUM_W-1:0]    p_sum;
  logic                p_valid;
  logic [SAMPLE_W-1:0] p_last;
  logic                p_taken;
  logic                p_move;

  logic                in_xfer;
  logic                running, sample_ok;
  logic [SAMPLE_W-1:0] sample_value;
  logic [TICK_W-1:0]   tick_inc;
  logic                due, take, full;
  logic [SAMPLE_W-1:0] ram_rdata, oldest;
  logic                ram_we;

  logic [SUM_W+DIV_M_W-1:0] quot_prod;
  logic [SAMPLE_W-1:0]      avg_calc;

  assign running      = s_tdata[IN_RUN_BIT];
  assign sample_value = s_tdata[IN_SAMPLE_LSB +: SAMPLE_W];
  assign sample_ok    = s_tdata[IN_OK_BIT];

  assign p_move   = p_v && (!m_tvalid || m_tready);
  assign s_tready = !p_v || p_move;
  assign in_xfer  = s_tvalid && s_tready;

  always_ff @(posedge clk) begin
    if (rst) begin
      sample_period <= PERIOD_RESET;
    end else if (cfg_we) begin
      sample_period <= cfg_wdata;
    end
  end

  // entries past the fill count were never written since the last stop
  assign full   = (fill_count == FILL_FULL);
  assign oldest = full ? ram_rdata : '0;

  assign tick_inc = (tick_count == TICK_MAX) ? TICK_MAX : tick_count + 1'b1;
  assign due      = (tick_inc >= TICK_W'(sample_period));
  assign take     = running && due && sample_ok;
  assign ram_we   = in_xfer && take;

  always_comb begin
    write_pos_next  = write_pos;
    fill_count_next = fill_count;
    window_sum_next = window_sum;
    tick_count_next = tick_count;
    last_count_next = last_count;
    if (in_xfer) begin
      if (!running) begin
        write_pos_next  = '0;
        fill_count_next = '0;
        window_sum_next = '0;
        tick_count_next = '0;
        last_count_next = '0;
      end else begin
        tick_count_next = due ? '0 : tick_inc;
        if (take) begin
          last_count_next = sample_value;
          window_sum_next = window_sum - SUM_W'(oldest) + SUM_W'(sample_value);
          write_pos_next  = (write_pos == POS_LAST) ? '0 : write_pos + 1'b1;
          fill_count_next = full ? fill_count : fill_count + 1'b1;
        end
      end
    end
  end

  // read address runs one step ahead so the oldest entry is ready on the next transfer
  tcma_ram #(
    .WIDTH (SAMPLE_W),
    .DEPTH (DEPTH)
  ) u_window (
    .clk   (clk),
    .we    (ram_we),
    .waddr (write_pos),
    .wdata (sample_value),
    .raddr (write_pos_next),
    .rdata (ram_rdata)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      write_pos  <= '0;
      fill_count <= '0;
      window_sum <= '0;
      tick_count <= '0;
      last_count <= '0;
    end else begin
      write_pos  <= write_pos_next;
      fill_count <= fill_count_next;
      window_sum <= window_sum_next;
      tick_count <= tick_count_next;
      last_count <= last_count_next;
    end
  end

  // stage between the state update and the divide
  always_ff @(posedge clk) begin
    if (rst) begin
      p_v <= 1'b0;
    end else if (in_xfer) begin
      p_v <= 1'b1;
    end else if (p_move) begin
      p_v <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_xfer) begin
      p_sum   <= window_sum_next;
      p_valid <= (fill_count_next == FILL_FULL);
      p_last  <= last_count_next;
      p_taken <= take;
    end
  end

  assign quot_prod = p_sum * DIV_M;
  assign avg_calc  = p_valid ? quot_prod[DIV_K +: SAMPLE_W] : '0;

  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (p_move) begin
      m_tvalid <= 1'b1;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (p_move) begin
      m_tdata <= {{(OUT_DATA_W - OUT_USED_W){1'b0}}, p_taken, p_last, p_valid, avg_calc};
    end
  end

  a_fill_bound: assert property (@(posedge clk) disable iff (rst)
    fill_count <= FILL_FULL)
    else $error("fill count beyond window depth");

  a_stop_clears: assert property (@(posedge clk) disable iff (rst)
    in_xfer && !running |=> fill_count == '0 && window_sum == '0 && tick_count == '0)
    else $error("stop tick did not clear filter state");

  a_pos_tracks_fill: assert property (@(posedge clk) disable iff (rst)
    fill_count < FILL_FULL |-> write_pos == fill_count[ADDR_W-1:0])
    else $error("ring pointer out of step with fill count");

  a_stage_holds: assert property (@(posedge clk) disable iff (rst)
    p_v && !p_move |=> p_v && $stable(p_sum) && $stable(p_taken))
    else $error("stalled stage lost its contents");

endmodule
